// ===== rtl/ltfb_pkg.sv =====
// Shared types, codes and helpers of the LED text frame buffer driver.
`default_nettype none

package ltfb_pkg;

	// Default configuration of the chip chain
	localparam int NUM_CHIPS_DEF        = 5;
	localparam int COLUMNS_PER_CHIP_DEF = 24;
	localparam int GLYPH_WIDTH_DEF      = 5;

	// Field widths
	localparam int CMD_W   = 3;
	localparam int LINE_W  = 2;
	localparam int COL_W   = 8;
	localparam int GLYPH_W = 40;
	localparam int PIX_W   = 8;
	localparam int FRAME_W = 16;
	localparam int WORD_W  = 16;
	localparam int CS_W    = 5;
	localparam int CHIP_W  = 3;
	localparam int LOCAL_W = 5;
	localparam int NIB_W   = 4;
	localparam int K_W     = 2;

	// Request commands
	localparam logic [CMD_W-1:0] CMD_BEGIN   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_GLYPH   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SCROLL  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_REFRESH = 3'd4;

	// Text lines
	localparam logic [LINE_W-1:0] LINE_LOW  = 2'd0;
	localparam logic [LINE_W-1:0] LINE_HIGH = 2'd1;
	localparam logic [LINE_W-1:0] LINE_MID  = 2'd2;
	localparam logic [LINE_W-1:0] LINE_BAD  = 2'd3;

	// Chip write opcode in the top bits of every data word
	localparam logic [2:0] WORD_PREFIX = 3'b101;

	// Buffer read address sources
	localparam logic [1:0] RD_CURSOR = 2'd0;
	localparam logic [1:0] RD_SCAN   = 2'd1;
	localparam logic [1:0] RD_COLUMN = 2'd2;

	// Buffer write sources
	localparam logic WR_GLYPH  = 1'b0;
	localparam logic WR_SCROLL = 1'b1;

	typedef struct packed {
		logic       latch;
		logic       apply_begin;
		logic       clear_buf;
		logic       rd_en;
		logic [1:0] rd_src;
		logic       wr_en;
		logic       wr_src;
		logic       drop_tail;
		logic       scan_clr;
		logic       scan_inc;
		logic       glyph_init;
		logic       glyph_inc;
		logic       cursor_adv;
		logic       emit;
		logic       emit_word;
	} ltfb_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] item_cmd;
		logic             item_bad;
		logic             glyph_more;
		logic             cursor_in;
		logic             scan_last;
		logic             word_last;
		logic             out_free;
	} ltfb_sts_t;

	function automatic logic [FRAME_W-1:0] line_mask(input logic [LINE_W-1:0] line);
		logic [FRAME_W-1:0] m;
		case (line)
			LINE_HIGH: m = 16'h00ff;
			LINE_MID:  m = 16'hf00f;
			default:   m = 16'hff00;
		endcase
		return m;
	endfunction

	function automatic logic [3:0] line_shift(input logic [LINE_W-1:0] line);
		logic [3:0] s;
		case (line)
			LINE_HIGH: s = 4'd8;
			LINE_MID:  s = 4'd4;
			default:   s = 4'd0;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/led_text_frame_buffer_driver.sv =====
// Top level of the LED text frame buffer driver: controller plus datapath.
// One request at a time; the next is taken the cycle after its last result is registered.
// Begin, clear and rejected requests: result registered after the dispatch and acknowledge states.
// Glyph: each stored column is read, then merged and written; a dropped column is skipped.
// Scroll shifts each column in turn; refresh: column read, then 4 words, 1 a cycle unless stalled.
// Reset clears the per-column valid bits, so the buffer reads zero at once, with no clearing pass.
`default_nettype none

module led_text_frame_buffer_driver #(
	parameter int NUM_CHIPS        = ltfb_pkg::NUM_CHIPS_DEF,
	parameter int COLUMNS_PER_CHIP = ltfb_pkg::COLUMNS_PER_CHIP_DEF,
	parameter int GLYPH_WIDTH      = ltfb_pkg::GLYPH_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [ltfb_pkg::CMD_W-1:0]    cmd,
	input  logic [ltfb_pkg::LINE_W-1:0]   text_line,
	input  logic [ltfb_pkg::COL_W-1:0]    column_index,
	input  logic                          proportional,
	input  logic [ltfb_pkg::GLYPH_W-1:0]  glyph_columns,
	// result channel
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic                          word_valid,
	output logic [ltfb_pkg::WORD_W-1:0]   spi_word,
	output logic [ltfb_pkg::CS_W-1:0]     chip_select,
	output logic                          status,
	output logic                          last
);
	import ltfb_pkg::*;

	ltfb_cmd_t ctl;
	ltfb_sts_t sts;

	// The controller takes a new request whenever it is idle, even while the previous
	// result still sits in the output register; it only holds when it must emit.
	ltfb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	// The datapath holds the column buffer (single read, single write port, registered
	// read data), the text cursor and line state, the glyph trim logic and the result
	// register that parts the two channels.
	ltfb_datapath #(
		.NUM_CHIPS        (NUM_CHIPS),
		.COLUMNS_PER_CHIP (COLUMNS_PER_CHIP),
		.GLYPH_WIDTH      (GLYPH_WIDTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.sts           (sts),
		.cmd           (cmd),
		.text_line     (text_line),
		.column_index  (column_index),
		.proportional  (proportional),
		.glyph_columns (glyph_columns),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.word_valid    (word_valid),
		.spi_word      (spi_word),
		.chip_select   (chip_select),
		.status        (status),
		.last          (last)
	);

endmodule

`default_nettype wire

// ===== rtl/ltfb_ctrl.sv =====
// Sequencing state machine of the LED text frame buffer driver.
`default_nettype none

module ltfb_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  ltfb_pkg::ltfb_sts_t   sts,
	output ltfb_pkg::ltfb_cmd_t   ctl
);
	import ltfb_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DISP = 3'd1;
	localparam logic [2:0] ST_GCHK = 3'd2;
	localparam logic [2:0] ST_GWR  = 3'd3;
	localparam logic [2:0] ST_SRD  = 3'd4;
	localparam logic [2:0] ST_SWR  = 3'd5;
	localparam logic [2:0] ST_WORD = 3'd6;
	localparam logic [2:0] ST_ACK  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		ctl       = '0;
		state_d   = state_q;
		req_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					ctl.latch = 1'b1;
					state_d   = ST_DISP;
				end
			end
			ST_DISP: begin
				case (sts.item_cmd)
					CMD_BEGIN: begin
						ctl.apply_begin = !sts.item_bad;
						state_d         = ST_ACK;
					end
					CMD_GLYPH: begin
						ctl.glyph_init = 1'b1;
						state_d        = ST_GCHK;
					end
					CMD_CLEAR: begin
						ctl.clear_buf = 1'b1;
						state_d       = ST_ACK;
					end
					CMD_SCROLL: begin
						ctl.scan_clr = 1'b1;
						state_d      = ST_SRD;
					end
					CMD_REFRESH: begin
						if (sts.item_bad) begin
							state_d = ST_ACK;
						end else begin
							ctl.rd_en  = 1'b1;
							ctl.rd_src = RD_COLUMN;
							state_d    = ST_WORD;
						end
					end
					default: begin
						state_d = ST_ACK;
					end
				endcase
			end
			ST_GCHK: begin
				if (sts.glyph_more) begin
					if (sts.cursor_in) begin
						ctl.rd_en  = 1'b1;
						ctl.rd_src = RD_CURSOR;
						state_d    = ST_GWR;
					end else begin
						// drop the column, still move on
						ctl.cursor_adv = 1'b1;
						ctl.glyph_inc  = 1'b1;
					end
				end else begin
					// skip the gap column
					ctl.cursor_adv = 1'b1;
					state_d        = ST_ACK;
				end
			end
			ST_GWR: begin
				ctl.wr_en      = 1'b1;
				ctl.wr_src     = WR_GLYPH;
				ctl.cursor_adv = 1'b1;
				ctl.glyph_inc  = 1'b1;
				state_d        = ST_GCHK;
			end
			ST_SRD: begin
				ctl.rd_en  = 1'b1;
				ctl.rd_src = RD_SCAN;
				state_d    = ST_SWR;
			end
			ST_SWR: begin
				ctl.wr_en  = 1'b1;
				ctl.wr_src = WR_SCROLL;
				if (sts.scan_last) begin
					ctl.drop_tail = 1'b1;
					state_d       = ST_ACK;
				end else begin
					ctl.scan_inc = 1'b1;
					state_d      = ST_SRD;
				end
			end
			ST_WORD: begin
				if (sts.out_free) begin
					ctl.emit      = 1'b1;
					ctl.emit_word = 1'b1;
					if (sts.word_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_ACK: begin
				if (sts.out_free) begin
					ctl.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_idle_no_mem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !(ctl.rd_en || ctl.wr_en))
		else $error("buffer access while idle");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |-> sts.out_free)
		else $error("result emitted into an occupied output register");

	a_last_word_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.emit && ctl.emit_word && sts.word_last) |=> (state_q == ST_IDLE))
		else $error("refresh did not finish after its final word");

endmodule

`default_nettype wire

// ===== rtl/ltfb_datapath.sv =====
// Frame buffer memory, cursor, glyph trimming and output register.
`default_nettype none

module ltfb_datapath #(
	parameter int NUM_CHIPS        = ltfb_pkg::NUM_CHIPS_DEF,
	parameter int COLUMNS_PER_CHIP = ltfb_pkg::COLUMNS_PER_CHIP_DEF,
	parameter int GLYPH_WIDTH      = ltfb_pkg::GLYPH_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ltfb_pkg::ltfb_cmd_t           ctl,
	output ltfb_pkg::ltfb_sts_t           sts,
	input  logic [ltfb_pkg::CMD_W-1:0]    cmd,
	input  logic [ltfb_pkg::LINE_W-1:0]   text_line,
	input  logic [ltfb_pkg::COL_W-1:0]    column_index,
	input  logic                          proportional,
	input  logic [ltfb_pkg::GLYPH_W-1:0]  glyph_columns,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic                          word_valid,
	output logic [ltfb_pkg::WORD_W-1:0]   spi_word,
	output logic [ltfb_pkg::CS_W-1:0]     chip_select,
	output logic                          status,
	output logic                          last
);
	import ltfb_pkg::*;

	localparam int BUF_COLS = NUM_CHIPS * COLUMNS_PER_CHIP;
	localparam int AW       = $clog2(BUF_COLS);
	localparam int GI_W     = $clog2(GLYPH_WIDTH);
	localparam int GC_W     = $clog2(GLYPH_WIDTH + 1);
	localparam int GEXT_W   = PIX_W * GLYPH_WIDTH;
	localparam logic [COL_W:0]  BUF_LIM  = (COL_W + 1)'(BUF_COLS);
	localparam logic [AW-1:0]   SCAN_END = AW'(BUF_COLS - 2);
	localparam logic [AW-1:0]   TAIL     = AW'(BUF_COLS - 1);
	localparam logic [GC_W-1:0] GW_C     = GC_W'(GLYPH_WIDTH);
	localparam logic [K_W-1:0]  K_LAST   = {K_W{1'b1}};

	// Latched request
	logic [CMD_W-1:0]   cmd_q;
	logic [LINE_W-1:0]  line_q;
	logic [COL_W-1:0]   col_q;
	logic               prop_q;
	logic [GLYPH_W-1:0] glyph_q;

	// Text state
	logic [COL_W-1:0]   cursor_q;
	logic [LINE_W-1:0]  active_line_q;
	logic               trim_q;

	// Sequencing counters
	logic [GC_W-1:0]    j_q;
	logic [GC_W-1:0]    end_q;
	logic [AW-1:0]      scan_q;
	logic [K_W-1:0]     k_q;

	// Buffer
	logic [FRAME_W-1:0] frame_q [BUF_COLS];
	logic [BUF_COLS-1:0] vld_q;
	logic [FRAME_W-1:0] rd_data_q;
	logic               rd_vld_q;
	logic [AW-1:0]      ra;
	logic [AW-1:0]      wa;
	logic [FRAME_W-1:0] wd;
	logic [FRAME_W-1:0] rd_col;

	// Glyph
	logic [GEXT_W-1:0]  gext;
	logic [PIX_W-1:0]   gcol [GLYPH_WIDTH];
	logic [GLYPH_WIDTH-1:0] nz;
	logic [GC_W-1:0]    first_c;
	logic [GC_W-1:0]    end_c;
	logic [FRAME_W-1:0] merged;

	// Refresh
	logic [CHIP_W-1:0]  chip_c;
	logic [COL_W-1:0]   base_c;
	logic [LOCAL_W-1:0] local_c;
	logic [CS_W-1:0]    cs_c;
	logic [NIB_W-1:0]   nib_c;
	logic [WORD_W-1:0]  word_c;

	logic               col_in;
	logic               item_bad;

	// Output register
	logic               rsp_valid_q;
	logic               word_valid_q;
	logic [WORD_W-1:0]  spi_word_q;
	logic [CS_W-1:0]    cs_q;
	logic               status_q;
	logic               last_q;

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q   <= cmd;
			line_q  <= text_line;
			col_q   <= column_index;
			prop_q  <= proportional;
			glyph_q <= glyph_columns;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q      <= '0;
			active_line_q <= LINE_LOW;
			trim_q        <= 1'b0;
		end else if (ctl.apply_begin) begin
			cursor_q      <= col_q;
			active_line_q <= line_q;
			trim_q        <= prop_q;
		end else if (ctl.cursor_adv && (cursor_q != {COL_W{1'b1}})) begin
			cursor_q      <= cursor_q + COL_W'(1);
		end
	end

	assign col_in = ({1'b0, col_q} < BUF_LIM);

	always_comb begin
		case (cmd_q)
			CMD_BEGIN:   item_bad = (line_q == LINE_BAD) || !col_in;
			CMD_GLYPH:   item_bad = 1'b0;
			CMD_CLEAR:   item_bad = 1'b0;
			CMD_SCROLL:  item_bad = 1'b0;
			CMD_REFRESH: item_bad = !col_in;
			default:     item_bad = 1'b1;
		endcase
	end

	// Glyph columns and proportional trim
	assign gext = GEXT_W'(glyph_q);

	always_comb begin
		for (int j = 0; j < GLYPH_WIDTH; j++) begin
			gcol[j] = gext[PIX_W*j +: PIX_W];
			nz[j]   = |gext[PIX_W*j +: PIX_W];
		end
	end

	always_comb begin
		first_c = '0;
		end_c   = GW_C;
		if (trim_q && (|nz)) begin
			for (int j = GLYPH_WIDTH - 1; j >= 0; j--) begin
				if (nz[j]) first_c = GC_W'(j);
			end
			end_c = '0;
			for (int j = 0; j < GLYPH_WIDTH; j++) begin
				if (nz[j]) end_c = GC_W'(j + 1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q   <= '0;
			end_q <= '0;
		end else if (ctl.glyph_init) begin
			j_q   <= first_c;
			end_q <= end_c;
		end else if (ctl.glyph_inc) begin
			j_q   <= j_q + GC_W'(1);
		end
	end

	assign merged = (rd_col & line_mask(active_line_q))
		| (FRAME_W'(gcol[j_q[GI_W-1:0]]) << line_shift(active_line_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else if (ctl.scan_clr) begin
			scan_q <= '0;
		end else if (ctl.scan_inc) begin
			scan_q <= scan_q + AW'(1);
		end
	end

	// Buffer ports
	always_comb begin
		case (ctl.rd_src)
			RD_SCAN:   ra = scan_q + AW'(1);
			RD_COLUMN: ra = col_q[AW-1:0];
			default:   ra = cursor_q[AW-1:0];
		endcase
	end

	assign wa = (ctl.wr_src == WR_SCROLL) ? scan_q : cursor_q[AW-1:0];
	assign wd = (ctl.wr_src == WR_SCROLL) ? rd_col : merged;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			frame_q[wa] <= wd;
		end
		if (ctl.rd_en) begin
			rd_data_q <= frame_q[ra];
		end
	end

	// Never-written and cleared columns read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (ctl.clear_buf) begin
				vld_q <= '0;
			end else begin
				if (ctl.wr_en) vld_q[wa] <= 1'b1;
				if (ctl.drop_tail) vld_q[TAIL] <= 1'b0;
			end
			if (ctl.rd_en) rd_vld_q <= vld_q[ra];
		end
	end

	assign rd_col = rd_vld_q ? rd_data_q : '0;

	// Chip and local column of the refresh column
	always_comb begin
		chip_c = '0;
		base_c = '0;
		for (int c = 1; c < NUM_CHIPS; c++) begin
			if (col_q >= COL_W'(c * COLUMNS_PER_CHIP)) begin
				chip_c = CHIP_W'(c);
				base_c = COL_W'(c * COLUMNS_PER_CHIP);
			end
		end
	end

	assign local_c = LOCAL_W'(col_q - base_c);
	assign cs_c    = (chip_c < CHIP_W'(CS_W)) ? (CS_W'(1) << chip_c) : '0;
	assign nib_c   = rd_col[NIB_W*k_q +: NIB_W];
	assign word_c  = {WORD_PREFIX, local_c, k_q, nib_c, 2'b00};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (ctl.latch) begin
			k_q <= '0;
		end else if (ctl.emit && ctl.emit_word) begin
			k_q <= k_q + K_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			word_valid_q <= ctl.emit_word;
			spi_word_q   <= ctl.emit_word ? word_c : '0;
			cs_q         <= ctl.emit_word ? cs_c : '0;
			status_q     <= ctl.emit_word ? 1'b0 : item_bad;
			last_q       <= ctl.emit_word ? (k_q == K_LAST) : 1'b1;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign word_valid  = word_valid_q;
	assign spi_word    = spi_word_q;
	assign chip_select = cs_q;
	assign status      = status_q;
	assign last        = last_q;

	always_comb begin
		sts            = '0;
		sts.item_cmd   = cmd_q;
		sts.item_bad   = item_bad;
		sts.glyph_more = (j_q < end_q);
		sts.cursor_in  = ({1'b0, cursor_q} < BUF_LIM);
		sts.scan_last  = (scan_q == SCAN_END);
		sts.word_last  = (k_q == K_LAST);
		sts.out_free   = !rsp_valid_q || !rsp_stall;
	end

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr_en |-> (int'(wa) < BUF_COLS))
		else $error("buffer write beyond the last column");

	a_clear_no_wr: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clear_buf |-> !(ctl.wr_en || ctl.drop_tail))
		else $error("buffer write during clear");

	a_rsp_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(ctl.emit))
		else $error("result appeared without an emit");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the LED text frame buffer driver, with its own frame buffer model.
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ltfb_pkg::*;

	localparam int BUF_COLS     = NUM_CHIPS_DEF * COLUMNS_PER_CHIP_DEF;
	localparam int TARGET_ITEMS = 460;
	// Longest request is a scroll, which steps through every buffer column, so wait that out and more
	localparam int DRAIN_CYCLES = 2 * BUF_COLS + 60;
	localparam int CYCLE_LIMIT  = 1_000_000;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [LINE_W-1:0]  line;
		logic [COL_W-1:0]   col;
		logic               prop;
		logic [GLYPH_W-1:0] glyph;
	} request_t;

	typedef struct packed {
		logic              word_valid;
		logic [WORD_W-1:0] word;
		logic [CS_W-1:0]   cs;
		logic              status;
		logic              last;
	} chip_write_t;

	// Mirror of the frame buffer and text cursor, plus the chip writes still owed by the block
	class frame_scoreboard;
		logic [FRAME_W-1:0] columns [BUF_COLS];
		logic [COL_W-1:0]   cursor;
		logic [LINE_W-1:0]  line;
		logic               trim;
		chip_write_t        owed [$];
		int                 errors;

		function new();
			foreach (columns[i]) columns[i] = '0;
			cursor = '0;
			line   = LINE_LOW;
			trim   = 1'b0;
			errors = 0;
		endfunction

		function void owe_ack(logic bad);
			chip_write_t w;
			w        = '0;
			w.status = bad;
			w.last   = 1'b1;
			owed.push_back(w);
		endfunction

		function void bump_cursor();
			if (cursor != 8'hFF)
				cursor++;
		endfunction

		function void note_request(request_t r);
			logic [PIX_W-1:0]   pix [GLYPH_WIDTH_DEF];
			logic [FRAME_W-1:0] keep;
			logic [FRAME_W-1:0] value;
			logic [6:0]         addr;
			chip_write_t        w;
			int                 shift, first, stop, chip, offs;
			case (r.cmd)
				CMD_BEGIN: begin
					if (r.line == LINE_BAD || r.col >= BUF_COLS) begin
						owe_ack(1'b1);
					end else begin
						line   = r.line;
						cursor = r.col;
						trim   = r.prop;
						owe_ack(1'b0);
					end
				end
				CMD_GLYPH: begin
					for (int j = 0; j < GLYPH_WIDTH_DEF; j++)
						pix[j] = r.glyph[PIX_W*j +: PIX_W];
					case (line)
						LINE_HIGH: begin keep = 16'h00ff; shift = 8; end
						LINE_MID:  begin keep = 16'hf00f; shift = 4; end
						default:   begin keep = 16'hff00; shift = 0; end
					endcase
					first = 0;
					stop  = GLYPH_WIDTH_DEF;
					if (trim) begin
						while (first < GLYPH_WIDTH_DEF && pix[first] == '0)
							first++;
						while (stop > 0 && pix[stop-1] == '0)
							stop--;
						// a blank glyph keeps its full width
						if (first == GLYPH_WIDTH_DEF) begin
							first = 0;
							stop  = GLYPH_WIDTH_DEF;
						end
					end
					for (int j = first; j < stop; j++) begin
						if (cursor < BUF_COLS)
							columns[cursor] = (columns[cursor] & keep)
								| (FRAME_W'(pix[j]) << shift);
						bump_cursor();
					end
					bump_cursor();
					owe_ack(1'b0);
				end
				CMD_CLEAR: begin
					foreach (columns[i]) columns[i] = '0;
					owe_ack(1'b0);
				end
				CMD_SCROLL: begin
					for (int i = 0; i < BUF_COLS - 1; i++)
						columns[i] = columns[i+1];
					columns[BUF_COLS-1] = '0;
					owe_ack(1'b0);
				end
				CMD_REFRESH: begin
					if (r.col >= BUF_COLS) begin
						owe_ack(1'b1);
					end else begin
						chip  = r.col / COLUMNS_PER_CHIP_DEF;
						offs  = r.col % COLUMNS_PER_CHIP_DEF;
						value = columns[r.col];
						for (int k = 0; k < 4; k++) begin
							addr         = 7'(offs * 4 + k);
							w.word_valid = 1'b1;
							w.word       = {WORD_PREFIX, addr, value[NIB_W*k +: NIB_W], 2'b00};
							w.cs         = (chip < CS_W) ? CS_W'(1 << chip) : '0;
							w.status     = 1'b0;
							w.last       = (k == 3);
							owed.push_back(w);
						end
					end
				end
				default: owe_ack(1'b1);
			endcase
		endfunction

		function void compare(string field, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_write(chip_write_t got);
			chip_write_t want;
			if (owed.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			want = owed.pop_front();
			compare("word_valid", want.word_valid, got.word_valid);
			compare("spi_word", want.word, got.word);
			compare("chip_select", want.cs, got.cs);
			compare("status", want.status, got.status);
			compare("last", want.last, got.last);
		endfunction
	endclass

	logic               clk;
	logic               arst_n        = 1'b0;
	logic               req_valid     = 1'b0;
	logic               req_stall;
	logic [CMD_W-1:0]   cmd           = CMD_BEGIN;
	logic [LINE_W-1:0]  text_line     = LINE_LOW;
	logic [COL_W-1:0]   column_index  = '0;
	logic               proportional  = 1'b0;
	logic [GLYPH_W-1:0] glyph_columns = '0;
	logic               rsp_valid;
	logic               rsp_stall     = 1'b0;
	logic               word_valid;
	logic [WORD_W-1:0]  spi_word;
	logic [CS_W-1:0]    chip_select;
	logic               status;
	logic               last;

	frame_scoreboard board;
	int              cycle_count   = 0;
	int              requests_sent = 0;

	led_text_frame_buffer_driver dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.cmd           (cmd),
		.text_line     (text_line),
		.column_index  (column_index),
		.proportional  (proportional),
		.glyph_columns (glyph_columns),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.word_valid    (word_valid),
		.spi_word      (spi_word),
		.chip_select   (chip_select),
		.status        (status),
		.last          (last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Count cycles and abandon a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Receiver back-pressure: quiet stretches, short blips and the odd long hold
	always @(posedge clk) begin : stall_gen
		int hold_left;
		int roll;
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			roll = $urandom_range(0, 99);
			if ((cycle_count / 300) % 3 == 0 || roll < 70) begin
				rsp_stall <= 1'b0;
			end else if (roll < 95) begin
				rsp_stall <= 1'b1;
				hold_left = $urandom_range(0, 2);
			end else begin
				rsp_stall <= 1'b1;
				hold_left = $urandom_range(10, 40);
			end
		end
	end

	// Sample results half a cycle early: outputs are settled and hold until the edge
	always @(negedge clk) begin : result_watch
		chip_write_t got;
		if (arst_n && rsp_valid && !rsp_stall) begin
			got = {word_valid, spi_word, chip_select, status, last};
			board.check_write(got);
		end
	end

	function automatic logic [GLYPH_W-1:0] any_glyph();
		return GLYPH_W'({$urandom, $urandom});
	endfunction

	// Random glyph, often with blank edge columns so that trimming has work to do
	function automatic logic [GLYPH_W-1:0] shape_glyph();
		logic [GLYPH_W-1:0] g;
		int mode, lead, tail, keep_col;
		g    = any_glyph();
		mode = $urandom_range(0, 9);
		lead = $urandom_range(1, GLYPH_WIDTH_DEF - 1);
		tail = $urandom_range(1, GLYPH_WIDTH_DEF - 1);
		case (mode)
			0: g = '0;
			1: for (int j = 0; j < lead; j++) g[PIX_W*j +: PIX_W] = '0;
			2: for (int j = GLYPH_WIDTH_DEF - tail; j < GLYPH_WIDTH_DEF; j++)
				g[PIX_W*j +: PIX_W] = '0;
			3: begin
				g[PIX_W*0 +: PIX_W] = '0;
				g[PIX_W*(GLYPH_WIDTH_DEF-1) +: PIX_W] = '0;
			end
			4: begin
				keep_col = $urandom_range(0, GLYPH_WIDTH_DEF - 1);
				for (int j = 0; j < GLYPH_WIDTH_DEF; j++)
					if (j != keep_col) g[PIX_W*j +: PIX_W] = '0;
			end
			default: ;
		endcase
		return g;
	endfunction

	// Present one request at a clock edge and hold it until the block takes it
	task automatic send_request(request_t r);
		cmd           <= r.cmd;
		text_line     <= r.line;
		column_index  <= r.col;
		proportional  <= r.prop;
		glyph_columns <= r.glyph;
		req_valid     <= 1'b1;
		@(negedge clk);
		while (req_stall)
			@(negedge clk);
		board.note_request(r);
		requests_sent++;
		@(posedge clk);
	endtask

	// Send a request, then maybe drop valid for a while
	task automatic issue(logic [CMD_W-1:0] c, logic [LINE_W-1:0] l, logic [COL_W-1:0] col,
			logic p, logic [GLYPH_W-1:0] g);
		request_t r;
		int       roll, gap;
		r = '{cmd: c, line: l, col: col, prop: p, glyph: g};
		send_request(r);
		roll = $urandom_range(0, 99);
		if ((cycle_count / 250) % 4 == 1 || roll < 60)
			gap = 0;
		else if (roll < 92)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(10, 40);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		int               scenario, n, start;
		logic [CMD_W-1:0] odd_cmd;
		board = new();
		// Hold reset, then release it on an edge
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: buffer reads zero after reset
		issue(CMD_REFRESH, 2'($urandom), 8'd0, 1'($urandom), any_glyph());
		// Low line, fixed width, a full glyph
		issue(CMD_BEGIN, LINE_LOW, 8'd0, 1'b0, any_glyph());
		issue(CMD_GLYPH, 2'($urandom), 8'($urandom), 1'($urandom), {GLYPH_W{1'b1}});
		issue(CMD_REFRESH, 2'($urandom), 8'd0, 1'($urandom), any_glyph());
		// High line with trimming of blank edges
		issue(CMD_BEGIN, LINE_HIGH, 8'd3, 1'b1, any_glyph());
		issue(CMD_GLYPH, 2'($urandom), 8'($urandom), 1'($urandom), 40'h00_1234_5600);
		issue(CMD_REFRESH, 2'($urandom), 8'd4, 1'($urandom), any_glyph());
		// Middle line: a blank glyph keeps its width, inner blanks stay
		issue(CMD_BEGIN, LINE_MID, 8'd10, 1'b1, any_glyph());
		issue(CMD_GLYPH, 2'($urandom), 8'($urandom), 1'($urandom), '0);
		issue(CMD_GLYPH, 2'($urandom), 8'($urandom), 1'($urandom), 40'hA5_0000_005A);
		issue(CMD_REFRESH, 2'($urandom), 8'd16, 1'($urandom), any_glyph());
		// Bad begin: invalid line, column just past the buffer, top column
		issue(CMD_BEGIN, LINE_BAD, 8'd5, 1'b1, any_glyph());
		issue(CMD_BEGIN, LINE_LOW, 8'(BUF_COLS), 1'b0, any_glyph());
		issue(CMD_BEGIN, LINE_HIGH, 8'hFF, 1'b1, any_glyph());
		// Glyph running off the end of the buffer
		issue(CMD_BEGIN, LINE_LOW, 8'(BUF_COLS - 3), 1'b0, any_glyph());
		issue(CMD_GLYPH, 2'($urandom), 8'($urandom), 1'($urandom), 40'hC3_C3C3_C3C3);
		issue(CMD_REFRESH, 2'($urandom), 8'(BUF_COLS - 1), 1'($urandom), any_glyph());
		// Bad refresh columns, then chip boundaries
		issue(CMD_REFRESH, 2'($urandom), 8'(BUF_COLS), 1'($urandom), any_glyph());
		issue(CMD_REFRESH, 2'($urandom), 8'hFF, 1'($urandom), any_glyph());
		issue(CMD_REFRESH, 2'($urandom), 8'(COLUMNS_PER_CHIP_DEF - 1), 1'b0, any_glyph());
		issue(CMD_REFRESH, 2'($urandom), 8'(COLUMNS_PER_CHIP_DEF), 1'b1, any_glyph());
		// Scroll, unknown commands, clear
		issue(CMD_SCROLL, 2'($urandom), 8'($urandom), 1'($urandom), any_glyph());
		issue(CMD_REFRESH, 2'($urandom), 8'd3, 1'($urandom), any_glyph());
		issue(CMD_REFRESH + 1'b1, 2'($urandom), 8'($urandom), 1'($urandom), any_glyph());
		issue({CMD_W{1'b1}}, 2'($urandom), 8'($urandom), 1'($urandom), any_glyph());
		issue(CMD_CLEAR, 2'($urandom), 8'($urandom), 1'($urandom), any_glyph());
		issue(CMD_REFRESH, 2'($urandom), 8'd15, 1'($urandom), any_glyph());

		// Random: mostly well-formed text runs, mixed with refresh, scroll, clear and noise
		while (requests_sent < TARGET_ITEMS) begin
			scenario = $urandom_range(0, 99);
			if (scenario < 50) begin
				start = ($urandom_range(0, 3) == 0) ? $urandom_range(BUF_COLS - 8, BUF_COLS - 1)
					: $urandom_range(0, BUF_COLS - 1);
				issue(CMD_BEGIN, 2'($urandom_range(LINE_LOW, LINE_MID)), 8'(start),
					1'($urandom), any_glyph());
				n = $urandom_range(1, 8);
				repeat (n)
					issue(CMD_GLYPH, 2'($urandom), 8'($urandom), 1'($urandom), shape_glyph());
				n = $urandom_range(0, 3);
				repeat (n)
					issue(CMD_REFRESH, 2'($urandom), 8'(start + $urandom_range(0, 12)),
						1'($urandom), any_glyph());
			end else if (scenario < 54) begin
				// Long run from near the end: drive the cursor into saturation
				issue(CMD_BEGIN, 2'($urandom_range(LINE_LOW, LINE_MID)),
					8'($urandom_range(BUF_COLS - 20, BUF_COLS - 1)), 1'($urandom), any_glyph());
				n = $urandom_range(24, 30);
				repeat (n)
					issue(CMD_GLYPH, 2'($urandom), 8'($urandom), 1'($urandom), shape_glyph());
				issue(CMD_REFRESH, 2'($urandom), 8'(BUF_COLS - 1), 1'($urandom), any_glyph());
			end else if (scenario < 78) begin
				n = $urandom_range(1, 6);
				repeat (n)
					issue(CMD_REFRESH, 2'($urandom),
						($urandom_range(0, 9) == 0) ? 8'($urandom) :
						8'($urandom_range(0, BUF_COLS - 1)), 1'($urandom), any_glyph());
			end else if (scenario < 84) begin
				issue(CMD_SCROLL, 2'($urandom), 8'($urandom), 1'($urandom), any_glyph());
			end else if (scenario < 87) begin
				issue(CMD_CLEAR, 2'($urandom), 8'($urandom), 1'($urandom), any_glyph());
			end else begin
				// Noise: any command, any fields, unknown codes among them
				odd_cmd = CMD_W'($urandom);
				issue(odd_cmd, 2'($urandom), 8'($urandom), 1'($urandom), any_glyph());
			end
		end
		req_valid <= 1'b0;

		// Drain: wait for every owed write, then watch for strays
		while (board.owed.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire
